/* hdl/rphd_pkg.sv */
// ----------------------------------------------------------------------------
// rphd_pkg
// Types, result codes, character codes and helpers for the profile decoder.
// ----------------------------------------------------------------------------
package rphd_pkg;

    // One incoming character of the hex-text profile.
    typedef struct packed {
        logic [7:0]  text_byte;
        logic        start_of_text;
        logic [16:0] text_size;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] decoded_byte;
    } out_item_t;

    // Result kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_LAST    = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_CORRUPT = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_F     = 8'h66;

    // Parse phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_SEEK_NL = 6'b000010,
        PH_SKIP_WS = 6'b000100,
        PH_NUMBER  = 6'b001000,
        PH_CHECK   = 6'b010000,
        PH_DECODE  = 6'b100000
    } phase_t;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= CH_A) && (c <= CH_F));
    endfunction

    // Nibble value of a lowercase hex digit; only meaningful when is_hex holds.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (is_dec(c))
        begin
            v = c[3:0];
        end
        else
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

/* hdl/rphd_step.sv */
// ----------------------------------------------------------------------------
// rphd_step
// Next-state and result logic for one character of the profile text.
// ----------------------------------------------------------------------------
module rphd_step
    import rphd_pkg::*;
#(
    parameter int MAX_TEXT_BYTES = 65536
)
(
    input  in_item_t                              item,
    input  phase_t                                phase,
    input  logic [$clog2(MAX_TEXT_BYTES)-1:0]     pos,
    input  logic [$clog2(MAX_TEXT_BYTES+1)-1:0]   size,
    input  logic [$clog2(MAX_TEXT_BYTES+1)-1:0]   acc,
    input  logic [$clog2(MAX_TEXT_BYTES+1)-1:0]   nib,
    input  logic [3:0]                            hn,
    output phase_t                                phase_next,
    output logic [$clog2(MAX_TEXT_BYTES)-1:0]     pos_next,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0]   size_next,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0]   acc_next,
    output logic [$clog2(MAX_TEXT_BYTES+1)-1:0]   nib_next,
    output logic [3:0]                            hn_next,
    output logic                                  res_valid,
    output out_item_t                             res_item
);

    localparam int PosW  = $clog2(MAX_TEXT_BYTES);
    localparam int SizeW = $clog2(MAX_TEXT_BYTES + 1);
    localparam int CmpW  = (SizeW > 17) ? SizeW : 17;
    localparam int MulW  = SizeW + 4;

    logic [CmpW-1:0]  ext_size;
    logic [SizeW-1:0] size_clamp;
    phase_t           phase_c;
    logic [PosW-1:0]  pos_c;
    logic [SizeW-1:0] size_c;
    logic [SizeW-1:0] acc_c;
    logic [SizeW-1:0] nib_c;
    logic [3:0]       hn_c;
    logic             last_char;
    logic [SizeW-1:0] remaining;
    logic [MulW-1:0]  acc_scaled;
    logic             do_number;
    logic             do_decode;
    logic [SizeW-1:0] nib_dec;
    logic [7:0]       c;

    assign c        = item.text_byte;
    assign ext_size = CmpW'(item.text_size);

    // Zero size counts as one; oversize clamps to the maximum.
    always_comb
    begin
        if (ext_size == '0)
        begin
            size_clamp = SizeW'(1);
        end
        else if (ext_size > CmpW'(MAX_TEXT_BYTES))
        begin
            size_clamp = SizeW'(MAX_TEXT_BYTES);
        end
        else
        begin
            size_clamp = SizeW'(ext_size);
        end
    end

    // A start flag opens a fresh text, dropping any open one.
    always_comb
    begin
        if (item.start_of_text)
        begin
            phase_c = PH_SEEK_NL;
            pos_c   = '0;
            size_c  = size_clamp;
            acc_c   = '0;
            nib_c   = '0;
            hn_c    = '0;
        end
        else
        begin
            phase_c = phase;
            pos_c   = pos;
            size_c  = size;
            acc_c   = acc;
            nib_c   = nib;
            hn_c    = hn;
        end
    end

    assign last_char  = (SizeW'(pos_c) + SizeW'(1)) >= size_c;
    assign remaining  = size_c - SizeW'(1) - SizeW'(pos_c);
    assign acc_scaled = MulW'(acc_c) * MulW'(10) + MulW'(c[3:0]);

    always_comb
    begin
        phase_next = phase_c;
        pos_next   = pos_c;
        size_next  = size_c;
        acc_next   = acc_c;
        nib_next   = nib_c;
        hn_next    = hn_c;
        res_valid  = 1'b0;
        res_item   = '0;
        do_number  = 1'b0;
        do_decode  = 1'b0;
        nib_dec    = nib_c;

        if (phase_c != PH_IDLE)
        begin
            pos_next = pos_c + PosW'(1);
            if (last_char)
            begin
                // final character is consumed unseen
                res_valid            = 1'b1;
                res_item.result_kind = (phase_c == PH_DECODE) ? KIND_CORRUPT : KIND_EMPTY;
                phase_next           = PH_IDLE;
            end
            else if (pos_c != '0)
            begin
                case (phase_c)
                    PH_SEEK_NL:
                    begin
                        if (c == CH_NL)
                        begin
                            phase_next = PH_SKIP_WS;
                        end
                    end
                    PH_SKIP_WS:
                    begin
                        if (!(c == CH_NUL || c == CH_SPACE || c == CH_NL))
                        begin
                            do_number = 1'b1;
                        end
                    end
                    PH_NUMBER:
                    begin
                        do_number = 1'b1;
                    end
                    PH_CHECK:
                    begin
                        if (acc_c > (remaining >> 1))
                        begin
                            res_valid            = 1'b1;
                            res_item.result_kind = KIND_CORRUPT;
                            phase_next           = PH_IDLE;
                        end
                        else if (acc_c == '0)
                        begin
                            res_valid            = 1'b1;
                            res_item.result_kind = KIND_EMPTY;
                            phase_next           = PH_IDLE;
                        end
                        else
                        begin
                            // length fits: this character starts the hex data
                            nib_dec    = {acc_c[SizeW-2:0], 1'b0};
                            nib_next   = nib_dec;
                            phase_next = PH_DECODE;
                            do_decode  = 1'b1;
                        end
                    end
                    PH_DECODE:
                    begin
                        do_decode = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                if (do_number)
                begin
                    if (is_dec(c))
                    begin
                        phase_next = PH_NUMBER;
                        // saturate at the maximum text size
                        if (acc_scaled > MulW'(MAX_TEXT_BYTES))
                        begin
                            acc_next = SizeW'(MAX_TEXT_BYTES);
                        end
                        else
                        begin
                            acc_next = SizeW'(acc_scaled);
                        end
                    end
                    else
                    begin
                        phase_next = PH_CHECK;
                    end
                end

                if (do_decode)
                begin
                    if (is_hex(c))
                    begin
                        nib_next = nib_dec - SizeW'(1);
                        if (!nib_dec[0])
                        begin
                            hn_next = hex_val(c);
                        end
                        else
                        begin
                            res_valid             = 1'b1;
                            res_item.decoded_byte = {hn_c, hex_val(c)};
                            if (nib_dec == SizeW'(1))
                            begin
                                res_item.result_kind = KIND_LAST;
                                phase_next           = PH_IDLE;
                            end
                            else
                            begin
                                res_item.result_kind = KIND_BYTE;
                            end
                        end
                    end
                    else if (c == CH_NUL)
                    begin
                        res_valid            = 1'b1;
                        res_item.result_kind = KIND_EMPTY;
                        phase_next           = PH_IDLE;
                    end
                end
            end
        end
    end

endmodule

/* hdl/rphd_out_stage.sv */
// ----------------------------------------------------------------------------
// rphd_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module rphd_out_stage
    import rphd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t load_item,
    input  logic      take,
    output logic      full,
    output logic      free,
    output out_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign free       = !valid_reg || take;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign full = valid_reg;
    assign item = item_reg;

endmodule

/* hdl/raw_profile_hex_decoder.sv */
// ----------------------------------------------------------------------------
// raw_profile_hex_decoder
// Decodes a hex-text profile (header line, decimal length, hex digit pairs)
// into bytes, one text character per cycle while no result is stalled.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                    Moves
//  -------   --------------------------------------   --------------------------
//  text      text_valid / text_ready / text_item      one character in per item
//  result    result_valid / result_ready / result_item  byte, last, empty or corrupt
//
//  Flow: one character per cycle while no result is stalled. An item is
//  parsed in the input register, and its result (if any) is loaded into the
//  result register when the item retires. The parse state lives beside the
//  input register, so the next character follows directly.
//  Reset: asynchronous, active low; parse phase returns to idle (no text open).
//  Stalls: a character that yields a result waits in the input register only
//  while the result register is full and not being taken; characters that
//  yield nothing pass through regardless.
//
module raw_profile_hex_decoder
    import rphd_pkg::*;
#(
    parameter int MAX_TEXT_BYTES = 65536
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      text_valid,
    output logic      text_ready,
    input  in_item_t  text_item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result_item
);

    localparam int PosW  = $clog2(MAX_TEXT_BYTES);
    localparam int SizeW = $clog2(MAX_TEXT_BYTES + 1);

    // input register
    logic             in_v_reg;
    logic             in_v_next;
    in_item_t         in_item_reg;

    // parse state
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [PosW-1:0]  pos_reg;
    logic [PosW-1:0]  pos_next;
    logic [SizeW-1:0] size_reg;
    logic [SizeW-1:0] size_next;
    logic [SizeW-1:0] acc_reg;
    logic [SizeW-1:0] acc_next;
    logic [SizeW-1:0] nib_reg;
    logic [SizeW-1:0] nib_next;
    logic [3:0]       hn_reg;
    logic [3:0]       hn_next;

    logic             step_res_v;
    out_item_t        step_res;
    logic             out_free;
    logic             out_full;
    logic             advance;
    logic             take_in;

    // The item in the input register retires when its result has room.
    assign advance    = in_v_reg && (!step_res_v || out_free);
    assign text_ready = !in_v_reg || advance;
    assign take_in    = text_valid && text_ready;
    assign in_v_next  = take_in || (in_v_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= in_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg <= text_item;
        end
    end

    rphd_step #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_step (
        .item       (in_item_reg),
        .phase      (phase_reg),
        .pos        (pos_reg),
        .size       (size_reg),
        .acc        (acc_reg),
        .nib        (nib_reg),
        .hn         (hn_reg),
        .phase_next (phase_next),
        .pos_next   (pos_next),
        .size_next  (size_next),
        .acc_next   (acc_next),
        .nib_next   (nib_next),
        .hn_next    (hn_next),
        .res_valid  (step_res_v),
        .res_item   (step_res)
    );

    // Parse state commits only when the item retires.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            size_reg  <= '0;
            acc_reg   <= '0;
            nib_reg   <= '0;
            hn_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            size_reg  <= size_next;
            acc_reg   <= acc_next;
            nib_reg   <= nib_next;
            hn_reg    <= hn_next;
        end
    end

    rphd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && step_res_v),
        .load_item (step_res),
        .take      (result_ready),
        .full      (out_full),
        .free      (out_free),
        .item      (result_item)
    );

    assign result_valid = out_full;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A result never lands on a full register that is not being emptied.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_full && !result_ready) |-> !(advance && step_res_v))
        else $error("result register overwritten");

    // Any terminating result closes the text.
    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res_v && step_res.result_kind != KIND_BYTE)
            |=> (phase_reg == PH_IDLE))
        else $error("text still open after final result");

    // While decoding there is always at least one nibble outstanding.
    a_nibbles_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DECODE) |-> (nib_reg != '0))
        else $error("decode phase with no nibbles left");

    // An open text never runs past its size.
    a_pos_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (SizeW'(pos_reg) < size_reg))
        else $error("byte position beyond text size");

endmodule
